/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL modules; included by mcp_decode.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, off during rst.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on clk, off during rst.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/mcp_pkg.sv */
// Types and constants of the MIDI channel message parser.
package mcp_pkg;

  // Message kinds on the result channel
  localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
  localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
  localparam logic [2:0] KIND_CONTROL  = 3'd2;
  localparam logic [2:0] KIND_PROGRAM  = 3'd3;
  localparam logic [2:0] KIND_BEND     = 3'd4;

  // Status byte high nibbles
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CONTROL  = 4'hB;
  localparam logic [3:0] ST_PROGRAM  = 4'hC;
  localparam logic [3:0] ST_BEND     = 4'hE;

  localparam logic [7:0] STATUS_NONE = 8'h00;

  // Parameter counts
  localparam logic [1:0] CNT_ZERO = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  typedef struct packed {
    logic [2:0] message_kind;
    logic [3:0] channel;
    logic [6:0] first_data;
    logic [6:0] second_data;
  } mcp_result_t;

  // Input stage toward the decoder
  typedef struct packed {
    logic       valid;
    logic [7:0] midi_byte;
  } mcp_stage_t;

  // Decoder toward the result register
  typedef struct packed {
    logic        load;
    mcp_result_t result;
  } mcp_load_t;

endpackage

/* hw/rtl/mcp_byte_if.sv */
// Request channel carrying one MIDI byte.
interface mcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;

  modport source (output valid, output midi_byte, input ready);
  modport sink (input valid, input midi_byte, output ready);
endinterface

/* hw/rtl/mcp_msg_if.sv */
// Request channel carrying one decoded channel message.
interface mcp_msg_if;
  logic       valid;
  logic       ready;
  logic [2:0] message_kind;
  logic [3:0] channel;
  logic [6:0] first_data;
  logic [6:0] second_data;

  modport source (output valid, output message_kind, output channel,
                  output first_data, output second_data, input ready);
  modport sink (input valid, input message_kind, input channel,
                input first_data, input second_data, output ready);
endinterface

/* hw/rtl/mcp_in_reg.sv */
// Input register: holds one received byte until the decoder takes it.
module mcp_in_reg (
  input  logic               clk,
  input  logic               rst,
  mcp_byte_if.sink           byte_in,
  input  logic               adv,
  output mcp_pkg::mcp_stage_t stage
);
  import mcp_pkg::*;

  logic       valid;
  logic [7:0] midi_byte;

  // Free slot, or the held byte leaves this cycle
  assign byte_in.ready = !valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (byte_in.ready) begin
      valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      midi_byte <= byte_in.midi_byte;
    end
  end

  assign stage.valid     = valid;
  assign stage.midi_byte = midi_byte;
endmodule

/* hw/rtl/mcp_decode.sv */
// Parser state and message decode for one byte per cycle, unless an emitting byte waits on a full result register.
module mcp_decode (
  input  logic               clk,
  input  logic               rst,
  input  mcp_pkg::mcp_stage_t stage,
  input  logic               out_free,
  output logic               adv,
  output mcp_pkg::mcp_load_t  load
);
  import mcp_pkg::*;
  `include "assert_macros.svh"

  logic [7:0] status, status_next;
  logic [1:0] cnt, cnt_next;
  logic [6:0] slot0, slot0_next;
  logic [6:0] slot1, slot1_next;
  logic [7:0] status_upd;
  logic [2:0] kind;
  logic [1:0] need;
  logic       known;
  logic       emit;

  // Byte update: status byte restarts, data byte fills the next slot
  always_comb begin
    status_upd = status;
    cnt_next   = cnt;
    slot0_next = slot0;
    slot1_next = slot1;
    if (stage.midi_byte[7]) begin
      status_upd = stage.midi_byte;
      cnt_next   = CNT_ZERO;
    end else if (cnt < CNT_TWO) begin
      if (cnt[0]) begin
        slot1_next = stage.midi_byte[6:0];
      end else begin
        slot0_next = stage.midi_byte[6:0];
      end
      cnt_next = cnt + CNT_ONE;
    end
  end

  // Status kind and parameter need
  always_comb begin
    kind  = KIND_NOTE_OFF;
    need  = CNT_TWO;
    known = 1'b1;
    unique case (status_upd[7:4])
      ST_NOTE_OFF: kind = KIND_NOTE_OFF;
      ST_NOTE_ON:  kind = KIND_NOTE_ON;
      ST_CONTROL:  kind = KIND_CONTROL;
      ST_PROGRAM: begin
        kind = KIND_PROGRAM;
        need = CNT_ONE;
      end
      ST_BEND:     kind = KIND_BEND;
      default:     known = 1'b0;
    endcase
  end

  assign emit        = known && (cnt_next == need);
  assign status_next = emit ? STATUS_NONE : status_upd;

  // A byte that emits nothing never waits on the result side
  assign adv = stage.valid && (out_free || !emit);

  assign load.load                = adv && emit;
  assign load.result.message_kind = kind;
  assign load.result.channel      = status_upd[3:0];
  assign load.result.first_data   = slot0_next;
  assign load.result.second_data  = (need == CNT_TWO) ? slot1_next : 7'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= STATUS_NONE;
      cnt    <= CNT_ZERO;
    end else if (adv) begin
      status <= status_next;
      cnt    <= cnt_next;
    end
  end

  // Slots are payload, undefined until written
  always_ff @(posedge clk) begin
    if (adv) begin
      slot0 <= slot0_next;
      slot1 <= slot1_next;
    end
  end

  `ASSERT_IMP(a_cnt_range, 1'b1, cnt != 2'd3)
  `ASSERT_NXT(a_status_clr, load.load, status == STATUS_NONE)
  `ASSERT_IMP(a_prog_second, load.load && (kind == KIND_PROGRAM),
              load.result.second_data == 7'd0)
endmodule

/* hw/rtl/mcp_out_reg.sv */
// Result register: holds one message until the sink takes it.
module mcp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  mcp_pkg::mcp_load_t load,
  output logic              out_free,
  mcp_msg_if.source         msg_out
);
  import mcp_pkg::*;

  logic        valid;
  mcp_result_t result;

  assign out_free = !valid || msg_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load.load) begin
      valid <= 1'b1;
    end else if (msg_out.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load.load) begin
      result <= load.result;
    end
  end

  assign msg_out.valid        = valid;
  assign msg_out.message_kind = result.message_kind;
  assign msg_out.channel      = result.channel;
  assign msg_out.first_data   = result.first_data;
  assign msg_out.second_data  = result.second_data;
endmodule

/* hw/rtl/midi_channel_message_parser.sv */
// Top level of the MIDI channel message parser.
//
//   channel   direction  payload
//   byte_in   in         midi_byte[7:0]
//   msg_out   out        message_kind[2:0], channel[3:0], first_data[6:0],
//                        second_data[6:0]
//
// One byte per cycle is accepted unless an emitting byte waits on a stalled
// result; a message passes the input register, then the result register.
// The parser state updates in the single decode step between the two.
// rst is synchronous and clears status, count and both valid flags.
// A stalled result blocks only a byte that would emit another message.
module midi_channel_message_parser (
  input  logic      clk,
  input  logic      rst,
  mcp_byte_if.sink  byte_in,
  mcp_msg_if.source msg_out
);
  import mcp_pkg::*;

  mcp_stage_t stage;
  mcp_load_t  load;
  logic       adv;
  logic       out_free;

  mcp_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .adv     (adv),
    .stage   (stage)
  );

  mcp_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .stage    (stage),
    .out_free (out_free),
    .adv      (adv),
    .load     (load)
  );

  mcp_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .out_free (out_free),
    .msg_out  (msg_out)
  );
endmodule
